FILE: rtl/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement - shared definitions
// Field widths, default sizes and the status record that the frame store
// hands to the top level for each processed request.
// ----------------------------------------------------------------------------
package lrupr_pkg;

   // default sizes of the frame set and of a stored page number
   localparam int MaxFramesDef   = 8;
   localparam int PageBitsDef    = 16;

   // frame count after reset
   localparam int FramesResetDef = 8;

   // fixed field widths of the channels
   localparam int PageW      = 16;
   localparam int FrameUsedW = 3;
   localparam int TotalW     = 32;
   localparam int CfgW       = 4;

   // result payload: fields plus zero fill to whole bytes
   localparam int RspFieldW = 1 + FrameUsedW + 1 + PageW + TotalW + TotalW;
   localparam int RspDataW  = ((RspFieldW + 7) / 8) * 8;
   localparam int RspPadW   = RspDataW - RspFieldW;

   localparam logic [TotalW-1:0] TotalMax = '1;

   // outcome of one lookup, as seen by the result channel
   typedef struct packed {
      logic                  was_hit;
      logic [FrameUsedW-1:0] frame_used;
      logic                  evicted_valid;
      logic [PageW-1:0]      evicted_page;
   } lrupr_status_type;

endpackage

FILE: rtl/lrupr_victim_select.sv
// ----------------------------------------------------------------------------
// LRU page replacement - victim select
// Picks the frame in use with the highest recency rank; on equal ranks the
// lowest-numbered frame wins. All pairwise compares run in parallel.
// ----------------------------------------------------------------------------
module lrupr_victim_select
   import lrupr_pkg::*;
#(
   parameter int MAX_FRAMES = MaxFramesDef,
   parameter int RANK_W     = 3
) (
   input  logic [RANK_W-1:0]     rank [MAX_FRAMES],
   input  logic [MAX_FRAMES-1:0] use_mask,
   output logic [MAX_FRAMES-1:0] victim_onehot
);

   // a frame wins if it beats every lower frame and ties or beats every higher one
   always_comb begin
      logic win;
      win = 1'b0;
      for (int f = 0; f < MAX_FRAMES; f++) begin
         win = use_mask[f];
         for (int g = 0; g < MAX_FRAMES; g++) begin
            if (g != f && use_mask[g]) begin
               if (g < f) begin
                  win = win & (rank[g] < rank[f]);
               end else begin
                  win = win & (rank[g] <= rank[f]);
               end
            end
         end
         victim_onehot[f] = win;
      end
   end

endmodule

FILE: rtl/lrupr_frame_store.sv
// ----------------------------------------------------------------------------
// LRU page replacement - frame store
// Holds page number, valid mark and recency rank per frame. Looks up one
// page per cycle, chooses the hit, empty or victim frame and applies the
// recency update when the step is enabled.
// ----------------------------------------------------------------------------
module lrupr_frame_store
   import lrupr_pkg::*;
#(
   parameter int MAX_FRAMES = MaxFramesDef,
   parameter int PAGE_BITS  = PageBitsDef
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic [PAGE_BITS-1:0]  step_page,
   input  logic [MAX_FRAMES-1:0] use_mask,
   output lrupr_status_type      status
);

   localparam int FrameW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam logic [FrameW-1:0] RankMax = FrameW'(MAX_FRAMES - 1);

   // frame state
   logic [PAGE_BITS-1:0]  page_ff  [MAX_FRAMES];
   logic [PAGE_BITS-1:0]  page_in  [MAX_FRAMES];
   logic [FrameW-1:0]     rank_ff  [MAX_FRAMES];
   logic [FrameW-1:0]     rank_in  [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] valid_ff;
   logic [MAX_FRAMES-1:0] valid_in;

   // lookup
   logic [MAX_FRAMES-1:0] match_vec;
   logic [MAX_FRAMES-1:0] empty_vec;
   logic [MAX_FRAMES-1:0] victim_vec;
   logic [MAX_FRAMES-1:0] sel_vec;
   logic                  found;
   logic                  has_empty;
   logic [FrameW-1:0]     slot;
   logic [FrameW-1:0]     age_limit;
   logic [PAGE_BITS-1:0]  victim_page;
   logic [FrameW+FrameUsedW-1:0] slot_wide;
   logic [PAGE_BITS+PageW-1:0]   page_wide;

   lrupr_victim_select #(
      .MAX_FRAMES (MAX_FRAMES),
      .RANK_W     (FrameW)
   ) u_victim (
      .rank          (rank_ff),
      .use_mask      (use_mask),
      .victim_onehot (victim_vec)
   );

   // compare every frame in use against the page
   always_comb begin
      for (int f = 0; f < MAX_FRAMES; f++) begin
         match_vec[f] = use_mask[f] & valid_ff[f] & (page_ff[f] == step_page);
         empty_vec[f] = use_mask[f] & ~valid_ff[f];
      end
   end

   assign found     = |match_vec;
   assign has_empty = |empty_vec;

   // lowest hit, else lowest empty frame, else the LRU victim
   always_comb begin
      if (found) begin
         sel_vec = match_vec & (~match_vec + MAX_FRAMES'(1));
      end else if (has_empty) begin
         sel_vec = empty_vec & (~empty_vec + MAX_FRAMES'(1));
      end else begin
         sel_vec = victim_vec;
      end
   end

   // encode the selected frame and fetch its page
   always_comb begin
      slot        = '0;
      victim_page = '0;
      for (int f = 0; f < MAX_FRAMES; f++) begin
         if (sel_vec[f]) begin
            slot        = slot | FrameW'(f);
            victim_page = victim_page | page_ff[f];
         end
      end
   end

   // a hit ages only frames more recent than the hit one
   assign age_limit = found ? rank_ff[slot] : RankMax;

   // next frame state
   always_comb begin
      for (int f = 0; f < MAX_FRAMES; f++) begin
         page_in[f]  = page_ff[f];
         rank_in[f]  = rank_ff[f];
         valid_in[f] = valid_ff[f];
         if (step_en) begin
            if (sel_vec[f]) begin
               rank_in[f] = '0;
               if (!found) begin
                  page_in[f]  = step_page;
                  valid_in[f] = 1'b1;
               end
            end else if (use_mask[f] && valid_ff[f] && (rank_ff[f] < age_limit)) begin
               rank_in[f] = rank_ff[f] + FrameW'(1);
            end
         end
      end
   end

   // hold frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int f = 0; f < MAX_FRAMES; f++) begin
            rank_ff[f] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         for (int f = 0; f < MAX_FRAMES; f++) begin
            rank_ff[f] <= rank_in[f];
         end
      end
   end

   // page numbers need no reset
   always_ff @(posedge clock) begin
      for (int f = 0; f < MAX_FRAMES; f++) begin
         page_ff[f] <= page_in[f];
      end
   end

   // fit frame index and page to the result field widths
   assign slot_wide = {{FrameUsedW{1'b0}}, slot};
   assign page_wide = {{PageW{1'b0}}, victim_page};

   always_comb begin
      status.was_hit       = found;
      status.frame_used    = slot_wide[FrameUsedW-1:0];
      status.evicted_valid = ~found & ~has_empty;
      status.evicted_page  = (~found & ~has_empty) ? page_wide[PageW-1:0] : '0;
   end

endmodule

FILE: rtl/lru_page_replacement_core.sv
// ----------------------------------------------------------------------------
// LRU page replacement core
// Page reference lookup with least-recently-used replacement over a small
// frame set, with saturating hit and fault totals.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one page reference per request (page in req_tdata).
//   rsp_* returns one result per request, in order: hit flag, frame used,
//   evicted flag and page, hit total and fault total.
//   csr_* writes the frame count (1..MAX_FRAMES; 0 acts as 1, larger values
//   as MAX_FRAMES). Write it only while no request is in flight.
// Path: an accepted request waits in the request register, is looked up
//   from there, and its result is loaded into the result register on rsp_*.
// Throughput: one request per cycle while rsp_tready is high; the frame set
//   is searched and its ranks updated between the request and result registers.
// Reset: all frames empty, ranks and totals zero, frame count 8.
// Stall: while rsp_tready is low the result register holds and one further
//   request is buffered in the request register; then req_tready drops.
// ----------------------------------------------------------------------------
module lru_page_replacement_core
   import lrupr_pkg::*;
#(
   parameter int MAX_FRAMES = MaxFramesDef,
   parameter int PAGE_BITS  = PageBitsDef
) (
   input  logic                clock,
   input  logic                reset,

   // request channel; tdata: page[15:0]
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [PageW-1:0]    req_tdata,

   // result channel; tdata: was_hit[0], frame_used[3:1], evicted_valid[4],
   // evicted_page[20:5], hit_total[52:21], fault_total[84:53], zero[87:85]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,

   // frame count write
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CfgW-1:0]     csr_data
);

   // request register
   logic                  req_valid_ff;
   logic                  req_valid_in;
   logic [PAGE_BITS-1:0]  req_page_ff;
   logic [PAGE_BITS-1:0]  req_page_in;
   logic [PAGE_BITS+PageW-1:0] req_page_wide;

   // result register and totals
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RspDataW-1:0]   rsp_data_ff;
   logic [RspDataW-1:0]   rsp_data_in;
   logic [TotalW-1:0]     hits_ff;
   logic [TotalW-1:0]     hits_in;
   logic [TotalW-1:0]     faults_ff;
   logic [TotalW-1:0]     faults_in;

   // frames in use
   logic [MAX_FRAMES-1:0] mask_ff;
   logic [MAX_FRAMES-1:0] mask_in;

   logic                  step;
   logic                  req_accept;
   lrupr_status_type      status;

   // advance when the request register is full and the result slot frees up
   assign step       = req_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~req_valid_ff | step;
   assign req_accept = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   lrupr_frame_store #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step),
      .step_page (req_page_ff),
      .use_mask  (mask_ff),
      .status    (status)
   );

   // fit the page to the stored width
   assign req_page_wide = {{PAGE_BITS{1'b0}}, req_tdata};

   // load or drain the request register
   always_comb begin
      req_valid_in = req_valid_ff;
      req_page_in  = req_page_ff;
      if (req_accept) begin
         req_valid_in = 1'b1;
         req_page_in  = req_page_wide[PAGE_BITS-1:0];
      end else if (step) begin
         req_valid_in = 1'b0;
      end
   end

   // bump the totals, saturating
   always_comb begin
      hits_in   = hits_ff;
      faults_in = faults_ff;
      if (step) begin
         if (status.was_hit) begin
            if (hits_ff != TotalMax) begin
               hits_in = hits_ff + TotalW'(1);
            end
         end else if (faults_ff != TotalMax) begin
            faults_in = faults_ff + TotalW'(1);
         end
      end
   end

   // load the result register on a step, drop it when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{RspPadW{1'b0}}, faults_in, hits_in, status.evicted_page,
                         status.evicted_valid, status.frame_used, status.was_hit};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // frame f is in use when it lies below the written count; frame 0 always
   always_comb begin
      mask_in = mask_ff;
      if (csr_valid) begin
         for (int f = 0; f < MAX_FRAMES; f++) begin
            mask_in[f] = (f == 0) || (f < int'(csr_data));
         end
      end
   end

   // hold control state and totals
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hits_ff      <= '0;
         faults_ff    <= '0;
         for (int f = 0; f < MAX_FRAMES; f++) begin
            mask_ff[f] <= (f < FramesResetDef);
         end
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hits_ff      <= hits_in;
         faults_ff    <= faults_in;
         mask_ff      <= mask_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_page_ff <= req_page_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // a result never reports both a hit and an eviction
   a_hit_no_evict : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[0] && rsp_data_ff[4]))
      else $error("result reports hit together with eviction");

   // every processed request moves one total unless it is saturated
   a_totals_move : assert property (@(posedge clock) disable iff (reset)
      step |=> (hits_ff != $past(hits_ff)) || (faults_ff != $past(faults_ff)) ||
               ($past(hits_ff) == TotalMax) || ($past(faults_ff) == TotalMax))
      else $error("totals did not advance on a processed request");

   // a result only appears after a step
   a_rsp_from_step : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step))
      else $error("result raised without a processed request");
`endif

endmodule

FILE: test/lru_page_replacement_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU page replacement core - regression bench
// Streams page references into the core under several frame counts. It also
// applies random result backpressure and request gaps. Every returned result is
// compared field by field against an in-bench LRU frame table that tracks
// hits, fills, evictions and the saturating totals.
// ----------------------------------------------------------------------------
module lru_page_replacement_core_test;
   import lrupr_pkg::*;

   localparam int FrameSlots = MaxFramesDef;
   localparam int RankTop    = FrameSlots - 1;
   localparam int PoolSize   = 12;

   // one expected result, unpacked
   typedef struct {
      bit                  was_hit;
      bit [FrameUsedW-1:0] frame_used;
      bit                  evicted_valid;
      bit [PageW-1:0]      evicted_page;
      bit [TotalW-1:0]     hit_total;
      bit [TotalW-1:0]     fault_total;
   } page_outcome_type;

   // frame table model plus the queue of outcomes still to arrive
   class page_table_scoreboard_type;
      bit [PageW-1:0]   frame_page [FrameSlots];
      bit               frame_valid [FrameSlots];
      bit [2:0]         frame_rank [FrameSlots];
      bit [TotalW-1:0]  hit_count;
      bit [TotalW-1:0]  fault_count;
      bit [CfgW-1:0]    frame_count;
      page_outcome_type outcome_q [$];
      int               failures;

      function new();
         for (int f = 0; f < FrameSlots; f++) begin
            frame_page[f]  = '0;
            frame_valid[f] = 1'b0;
            frame_rank[f]  = '0;
         end
         hit_count   = '0;
         fault_count = '0;
         frame_count = CfgW'(FramesResetDef);
         failures    = 0;
      endfunction

      function void set_frame_count(bit [CfgW-1:0] value);
         frame_count = value;
      endfunction

      function int pending();
         return outcome_q.size();
      endfunction

      // zero acts as one, anything above the frame set as the full set
      function int frames_active();
         if (frame_count == 0)
            return 1;
         if (frame_count > FrameSlots)
            return FrameSlots;
         return frame_count;
      endfunction

      // bump ranks below limit for valid frames in use, skipping one frame
      function void age_frames(int used, int skip, int unsigned limit);
         for (int f = 0; f < used; f++) begin
            if (f != skip && frame_valid[f] && frame_rank[f] < limit &&
                frame_rank[f] < RankTop)
               frame_rank[f] = frame_rank[f] + 3'd1;
         end
      endfunction

      // look up one page reference and queue the outcome it must produce
      function void note_reference(bit [PageW-1:0] page);
         page_outcome_type o;
         int               used;
         int               slot;
         bit               found;
         bit               empty;
         bit [2:0]         oldest;
         used    = frames_active();
         slot    = 0;
         found   = 1'b0;
         empty   = 1'b0;
         o.evicted_valid = 1'b0;
         o.evicted_page  = '0;
         for (int f = 0; f < used; f++) begin
            if (!found && frame_valid[f] && frame_page[f] == page) begin
               slot  = f;
               found = 1'b1;
            end
         end
         if (found) begin
            age_frames(used, slot, frame_rank[slot]);
            frame_rank[slot] = '0;
            if (hit_count != TotalMax)
               hit_count++;
         end else begin
            // fill the lowest empty frame, else evict the oldest one
            for (int f = 0; f < used; f++) begin
               if (!empty && !frame_valid[f]) begin
                  slot  = f;
                  empty = 1'b1;
               end
            end
            if (!empty) begin
               oldest = '0;
               slot   = 0;
               for (int f = 0; f < used; f++) begin
                  if (f == 0 || frame_rank[f] > oldest) begin
                     oldest = frame_rank[f];
                     slot   = f;
                  end
               end
               o.evicted_valid = 1'b1;
               o.evicted_page  = frame_page[slot];
            end
            age_frames(used, slot, 32'hFFFF_FFFF);
            frame_page[slot]  = page;
            frame_valid[slot] = 1'b1;
            frame_rank[slot]  = '0;
            if (fault_count != TotalMax)
               fault_count++;
         end
         o.was_hit     = found;
         o.frame_used  = slot[FrameUsedW-1:0];
         o.hit_total   = hit_count;
         o.fault_total = fault_count;
         outcome_q = {outcome_q, o};
      endfunction

      // compare one returned result with the oldest queued outcome
      function void check_outcome(logic [RspDataW-1:0] data);
         page_outcome_type want;
         page_outcome_type got;
         got.was_hit       = data[0];
         got.frame_used    = data[3:1];
         got.evicted_valid = data[4];
         got.evicted_page  = data[20:5];
         got.hit_total     = data[52:21];
         got.fault_total   = data[84:53];
         if (outcome_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result at %0t: data %h", $realtime, data);
            return;
         end
         want = outcome_q.pop_front();
         if (got.was_hit != want.was_hit || got.frame_used != want.frame_used ||
             got.evicted_valid != want.evicted_valid ||
             got.evicted_page != want.evicted_page ||
             got.hit_total != want.hit_total || got.fault_total != want.fault_total)
         begin
            failures++;
            if (failures <= 10) begin
               $display("result mismatch at %0t", $realtime);
               $display("  expected hit %0d frame %0d evict %0d page %h hits %0d faults %0d",
                        want.was_hit, want.frame_used, want.evicted_valid,
                        want.evicted_page, want.hit_total, want.fault_total);
               $display("  actual   hit %0d frame %0d evict %0d page %h hits %0d faults %0d",
                        got.was_hit, got.frame_used, got.evicted_valid,
                        got.evicted_page, got.hit_total, got.fault_total);
            end
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [PageW-1:0]    req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_valid;
   logic                csr_ready;
   logic [CfgW-1:0]     csr_data;

   bit                  steady;
   logic [PageW-1:0]    page_pool [PoolSize];
   page_table_scoreboard_type sb;

   lru_page_replacement_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // clock and known input levels from time zero
   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      steady     = 1'b0;
      sb         = new();
   end

   always #5 clock = ~clock;

   // result side backpressure
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 18);
   end

   // check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_outcome(rsp_tdata);
   end

   // present one page reference and hold it until it is taken
   task automatic send_page(input logic [PageW-1:0] page);
      if (!steady && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= page;
      do @(posedge clock); while (!req_tready);
      sb.note_reference(page);
      @(negedge clock);
   endtask

   // drain outstanding requests, then write the frame count
   task automatic write_frame_count(input logic [CfgW-1:0] value);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_frame_count(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // main sequence
   initial begin
      logic [CfgW-1:0]  count;
      logic [PageW-1:0] page;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // full frame set: extremes, a hit, fill every frame, then evict
      write_frame_count(4'd8);
      send_page(16'h0000);
      send_page(16'hFFFF);
      send_page(16'h0000);
      for (int p = 1; p <= 6; p++)
         send_page(p[PageW-1:0]);
      send_page(16'h8000);
      send_page(16'hFFFF);
      send_page(16'h0003);

      // shrink: a page parked in an upper frame faults into a low one
      write_frame_count(4'd2);
      send_page(16'h0005);
      send_page(16'h5555);

      // oversized count acts as the full set; the duplicate hits low frame
      write_frame_count(4'd15);
      send_page(16'h0005);
      send_page(16'hAAAA);

      // zero acts as a single frame
      write_frame_count(4'd0);
      send_page(16'h1234);
      send_page(16'h1234);
      send_page(16'h4321);

      write_frame_count(4'd1);
      send_page(16'h4321);
      send_page(16'h00FF);

      // random phases over a mostly reused page pool
      for (int k = 0; k < PoolSize; k++)
         page_pool[k] = PageW'($urandom);
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: count = 4'd8;
            1: count = 4'd1;
            2: count = 4'd3;
            3: count = 4'd0;
            4: count = 4'd15;
            5: count = 4'd5;
            7: count = 4'd8;
            8: count = 4'd2;
            default: count = CfgW'($urandom_range(15));
         endcase
         write_frame_count(count);
         for (int k = 0; k < PoolSize; k++)
            if ($urandom_range(1))
               page_pool[k] = PageW'($urandom);
         steady = (phase == 4);
         for (int n = 0; n < 68; n++) begin
            if ($urandom_range(99) < 85)
               page = page_pool[$urandom_range(PoolSize - 1)];
            else
               page = PageW'($urandom);
            send_page(page);
         end
      end
      steady = 1'b0;

      // drain and let the pipeline settle
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (sb.failures == 0)
         $display("lru_page_replacement_core regression: pass");
      else
         $display("lru_page_replacement_core regression: fail");
      $finish;
   end

   // hang guard
   initial begin
      #2000000;
      $display("lru_page_replacement_core regression: fail");
      $finish;
   end

endmodule

FILE: files.f
rtl/lrupr_pkg.sv
rtl/lrupr_victim_select.sv
rtl/lrupr_frame_store.sv
rtl/lru_page_replacement_core.sv
test/lru_page_replacement_core_test.sv
